[sv/trigger_frame_sync_matcher_assert.svh]
// ---------------------------------------------------------------------------
// trigger frame sync matcher assertion macros
// implication checks on the block clock, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef TRIGGER_FRAME_SYNC_MATCHER_ASSERT_SVH
`define TRIGGER_FRAME_SYNC_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TFSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TFSM_ASSERT_IMP(label, ante, cons, msg)
`define TFSM_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[sv/tfsm_pkg.sv]
// ---------------------------------------------------------------------------
// tfsm_pkg
// shared types, codes and constants of the trigger frame sync matcher
// ---------------------------------------------------------------------------
package tfsm_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int QW          = $clog2(QUEUE_DEPTH);

  localparam int TIME_W  = 64;
  localparam int COUNT_W = 32;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_TRIGGER = 2'd0,
    REQ_FRAME   = 2'd1,
    REQ_TICK    = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    ST_STORED      = 4'd0,
    ST_DROP        = 4'd1,
    ST_TRIG_STAMP  = 4'd2,
    ST_OWN_STAMP   = 4'd3,
    ST_HELD        = 4'd4,
    ST_FAIL_COUNT  = 4'd5,
    ST_FAIL_FUTURE = 4'd6,
    ST_FAIL_OLD    = 4'd7,
    ST_FAIL_SYNC   = 4'd8,
    ST_ENABLE      = 4'd9,
    ST_IDLE        = 4'd10,
    ST_BUSY        = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    REG_TRIGGER_MODE = 2'd0,
    REG_MAX_LATENCY  = 2'd1,
    REG_RESYNC       = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              trigger_mode_on;
    logic [31:0]       max_latency_us;
    logic [31:0]       resync_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  trig_time;
    logic [COUNT_W-1:0] trig_count;
  } entry_t;

  typedef struct packed {
    status_t           status;
    logic [TIME_W-1:0] stamp;
    logic              last;
  } result_t;

  function automatic logic [QW-1:0] next_index(input logic [QW-1:0] idx);
    if (idx == QW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return idx + QW'(1);
  endfunction

endpackage

[sv/tfsm_head_mem.sv]
// ---------------------------------------------------------------------------
// tfsm_head_mem
// trigger queue memory with a prefetched head entry and write forwarding
// ---------------------------------------------------------------------------
module tfsm_head_mem import tfsm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [QW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [QW-1:0] rd_addr,
  output entry_t        head
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;
  entry_t byp_data_r;
  logic   byp_r;
  logic   byp_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // read-first memory: a write to the entry being fetched is forwarded
  assign byp_nxt = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wr_data;
  end

  assign head = byp_r ? byp_data_r : rd_data_r;

endmodule

[sv/tfsm_cfg_regs.sv]
// ---------------------------------------------------------------------------
// tfsm_cfg_regs
// apb configuration registers: trigger mode, latency limit, resync timeout
// ---------------------------------------------------------------------------
module tfsm_cfg_regs import tfsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_TRIGGER_MODE: cfg_nxt.trigger_mode_on   = pwdata[0];
        REG_MAX_LATENCY:  cfg_nxt.max_latency_us    = pwdata;
        REG_RESYNC:       cfg_nxt.resync_timeout_us = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRIGGER_MODE: prdata = {{(CFG_DW-1){1'b0}}, cfg_r.trigger_mode_on};
      REG_MAX_LATENCY:  prdata = cfg_r.max_latency_us;
      REG_RESYNC:       prdata = cfg_r.resync_timeout_us;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_mode_on   <= 1'b0;
      cfg_r.max_latency_us    <= 32'd60000;
      cfg_r.resync_timeout_us <= 32'd1000000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/tfsm_result_q.sv]
// ---------------------------------------------------------------------------
// tfsm_result_q
// small result queue, takes up to two results a cycle, hands out one unless out_stall is high
// ---------------------------------------------------------------------------
module tfsm_result_q import tfsm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push0,
  input  result_t data0,
  input  logic    push1,
  input  result_t data1,
  output logic    near_full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t          q_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wp_r, wp_nxt;
  logic [RQ_AW-1:0] rp_r, rp_nxt;
  logic [RQ_CW-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [RQ_CW-1:0] n_push;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rp_r];
  assign pop       = out_valid && !out_stall;
  // room is kept for the two results an input may cause
  assign near_full = (cnt_r > RQ_CW'(RQ_DEPTH - 2));
  assign n_push    = RQ_CW'(push0) + RQ_CW'(push1);

  always_comb begin
    wp_nxt  = wp_r + RQ_AW'(n_push);
    rp_nxt  = rp_r + RQ_AW'(pop);
    cnt_nxt = cnt_r + n_push - RQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      q_r[wp_r] <= data0;
    end
    if (push1) begin
      q_r[wp_r + RQ_AW'(1)] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/trigger_frame_sync_matcher.sv]
// ---------------------------------------------------------------------------
// trigger_frame_sync_matcher: results of accepted input transactions are queued for output
// throughput 1 input transaction per cycle unless in_stall; results leave one at a time
// head entry is prefetched from the queue memory, read at the next read index
// sync reset initialises indexes, counts and flags; queue memory is not cleared
// ---------------------------------------------------------------------------
`include "trigger_frame_sync_matcher_assert.svh"

module trigger_frame_sync_matcher import tfsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input transactions
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [TIME_W-1:0]  in_event_time,
  input  logic [COUNT_W-1:0] in_trigger_count,
  // result transactions
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_status,
  output logic [TIME_W-1:0]  out_stamp,
  output logic               out_last,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t cfg;

  // queue pointers and sync state
  logic [QW-1:0]      rd_idx_r,  rd_idx_nxt;
  logic [QW-1:0]      wr_idx_r,  wr_idx_nxt;
  logic [COUNT_W-1:0] exp_cnt_r, exp_cnt_nxt;
  logic [COUNT_W-1:0] last_cnt_r, last_cnt_nxt;
  logic               oos_r,     oos_nxt;
  logic [TIME_W-1:0]  last_trig_r, last_trig_nxt;
  logic               fw_r,      fw_nxt;
  logic [TIME_W-1:0]  wait_time_r, wait_time_nxt;

  logic    accept;
  logic    q_full;
  logic    q_empty;
  entry_t  head;
  entry_t  in_entry;
  logic    mem_we;

  // frame check against the queue head, or the arriving trigger for a held frame
  entry_t            chk_entry;
  logic [TIME_W-1:0] chk_now;
  logic [TIME_W-1:0] chk_age;
  status_t           chk_status;
  logic              chk_fail;
  logic [TIME_W-1:0] tick_gap;
  logic              tick_enable;

  result_t res0, res1;
  logic    push0, push1;
  logic    rq_near_full;
  result_t out_res;

  tfsm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_entry.trig_time  = in_event_time;
  assign in_entry.trig_count = in_trigger_count;

  // read address follows the next read index, so head always holds the entry at rd_idx_r
  tfsm_head_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (wr_idx_r),
    .wr_data (in_entry),
    .rd_addr (rd_idx_nxt),
    .head    (head)
  );

  assign in_stall = rq_near_full;
  assign accept   = in_valid && !in_stall;
  assign q_full   = (rd_idx_r == next_index(wr_idx_r));
  assign q_empty  = (rd_idx_r == wr_idx_r);

  // a held frame is checked against the trigger that arrives now; queue was empty,
  // so that trigger is the head
  always_comb begin
    if (fw_r) begin
      chk_entry = in_entry;
      chk_now   = wait_time_r;
    end else begin
      chk_entry = head;
      chk_now   = in_event_time;
    end
    chk_age = chk_now - chk_entry.trig_time;
    if (chk_entry.trig_count != exp_cnt_r) begin
      chk_status = ST_FAIL_COUNT;
    end else if (chk_entry.trig_time > chk_now) begin
      chk_status = ST_FAIL_FUTURE;
    end else if (chk_age > {32'd0, cfg.max_latency_us}) begin
      chk_status = ST_FAIL_OLD;
    end else begin
      chk_status = ST_TRIG_STAMP;
    end
    chk_fail = (chk_status != ST_TRIG_STAMP);
  end

  // silence since the last trigger for the re-enable request
  assign tick_gap    = in_event_time - last_trig_r;
  assign tick_enable = cfg.trigger_mode_on && (in_event_time > last_trig_r) &&
                       (tick_gap > {32'd0, cfg.resync_timeout_us});

  always_comb begin
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    exp_cnt_nxt   = exp_cnt_r;
    last_cnt_nxt  = last_cnt_r;
    oos_nxt       = oos_r;
    last_trig_nxt = last_trig_r;
    fw_nxt        = fw_r;
    wait_time_nxt = wait_time_r;
    mem_we        = 1'b0;
    push0         = 1'b0;
    push1         = 1'b0;
    res0          = '{status: ST_IDLE, stamp: '0, last: 1'b1};
    res1          = '{status: ST_IDLE, stamp: '0, last: 1'b1};

    if (accept) begin
      push0 = 1'b1;
      unique case (in_req_type)
        REQ_TRIGGER: begin
          last_trig_nxt = in_event_time;
          res0.last     = !fw_r;
          if (q_full) begin
            res0.status = ST_DROP;
          end else begin
            mem_we       = 1'b1;
            wr_idx_nxt   = next_index(wr_idx_r);
            last_cnt_nxt = in_trigger_count;
            res0.status  = ST_STORED;
          end
          // second result: the held frame
          if (fw_r) begin
            fw_nxt = 1'b0;
            push1  = 1'b1;
            if (rd_idx_r == wr_idx_nxt) begin
              res1.status = ST_FAIL_SYNC;
              oos_nxt     = 1'b1;
              rd_idx_nxt  = wr_idx_nxt;
              exp_cnt_nxt = last_cnt_nxt + COUNT_W'(1);
            end else begin
              res1.status = chk_status;
              if (chk_fail) begin
                oos_nxt     = 1'b1;
                rd_idx_nxt  = wr_idx_nxt;
                exp_cnt_nxt = last_cnt_nxt + COUNT_W'(1);
              end else begin
                rd_idx_nxt  = next_index(rd_idx_r);
                exp_cnt_nxt = exp_cnt_r + COUNT_W'(1);
                res1.stamp  = chk_entry.trig_time;
              end
            end
          end
        end
        REQ_FRAME: begin
          if (fw_r) begin
            res0.status = ST_BUSY;
          end else if (!cfg.trigger_mode_on) begin
            res0.status = ST_OWN_STAMP;
            res0.stamp  = in_event_time;
          end else if (oos_r) begin
            res0.status = ST_FAIL_SYNC;
            rd_idx_nxt  = wr_idx_r;
            exp_cnt_nxt = last_cnt_r + COUNT_W'(1);
          end else if (q_empty) begin
            res0.status   = ST_HELD;
            fw_nxt        = 1'b1;
            wait_time_nxt = in_event_time;
          end else begin
            res0.status = chk_status;
            if (chk_fail) begin
              oos_nxt     = 1'b1;
              rd_idx_nxt  = wr_idx_r;
              exp_cnt_nxt = last_cnt_r + COUNT_W'(1);
            end else begin
              rd_idx_nxt  = next_index(rd_idx_r);
              exp_cnt_nxt = exp_cnt_r + COUNT_W'(1);
              res0.stamp  = chk_entry.trig_time;
            end
          end
        end
        REQ_TICK: begin
          if (tick_enable) begin
            res0.status = ST_ENABLE;
            oos_nxt     = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      exp_cnt_r   <= '0;
      last_cnt_r  <= '1;
      oos_r       <= 1'b0;
      last_trig_r <= '0;
      fw_r        <= 1'b0;
      wait_time_r <= '0;
    end else begin
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      last_cnt_r  <= last_cnt_nxt;
      oos_r       <= oos_nxt;
      last_trig_r <= last_trig_nxt;
      fw_r        <= fw_nxt;
      wait_time_r <= wait_time_nxt;
    end
  end

  // results wait here so new input transactions keep flowing under output stall until it nears full
  tfsm_result_q u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .data0     (res0),
    .push1     (push1),
    .data1     (res1),
    .near_full (rq_near_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_status = out_res.status;
  assign out_stamp  = out_res.stamp;
  assign out_last   = out_res.last;

  // a frame is held only while the trigger queue is empty
  `TFSM_ASSERT_IMP(a_held_queue_empty, fw_r, rd_idx_r == wr_idx_r, "held frame with queue not empty")
  // a frame is never held while out of sync
  `TFSM_ASSERT_IMP(a_held_in_sync, fw_r, !oos_r, "held frame while out of sync")
  // a stored trigger advances the write index
  `TFSM_ASSERT_NXT(a_store_advances, mem_we, wr_idx_r != $past(wr_idx_r), "write index stuck")

endmodule
